/* hdl/ipv4_fragment_header_generator_defines.svh */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Shared property wrappers for the port checker. The enclosing module must
// provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IFHG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IFHG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ifhg_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Word types, header constants and register codes.
// ----------------------------------------------------------------------------
package ifhg_pkg;

  localparam int HDR_BYTES    = 20;
  localparam int MAX_RESULTS  = 45;
  localparam int FRAG_CNT_W   = $clog2(MAX_RESULTS);
  // Nine 16-bit words summed before folding stay below 2^20.
  localparam int ACC_W        = 20;

  // Version 4, header length 5 words, TOS 0.
  localparam logic [15:0] VER_IHL_TOS = 16'h4500;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE   = 2'd1;

  localparam logic [7:0] TTL_RESET = 8'd64;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [31:0] dest_address;
    logic [7:0]  proto_number;
  } in_word_t;

  typedef struct packed {
    logic [15:0] payload_start;
    logic [10:0] fragment_payload_length;
    logic [10:0] total_length;
    logic [15:0] packet_id;
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [15:0] header_checksum;
    logic        last_fragment;
  } out_word_t;

endpackage

/* hdl/ipv4_fragment_header_generator.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Splits one send request into MTU-sized fragments and emits one header
// description word per fragment, including the IPv4 header checksum.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | in_word_t  (send request)
//  out_    | output    | out_valid/out_stall| out_word_t (one per fragment)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index + cfg_data
//
//  Sequence: accept, then the BASE phase sums the six fixed header words,
//  then each fragment runs total-length add, flags add, two folds and emit;
//  emit holds while out_stall is high. All sums go through one 20-bit adder.
//  Reset is synchronous: it clears the sequencer, the packet id counter and
//  the configuration registers (source 0, TTL 64).
//  in_stall is high from accept until the last fragment word is taken.
//  cfg_ready is always high; writes take effect on the next cycle.
//
module ipv4_fragment_header_generator import ifhg_pkg::*; #(
  parameter int MTU_BYTES = 1500
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  // fragment channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Payload per non-final fragment: MTU minus header, rounded down to 8 bytes.
  localparam int FRAG_UNIT_RAW = ((MTU_BYTES - HDR_BYTES) / 8) * 8;
  localparam int FRAG_UNIT     = (FRAG_UNIT_RAW < 8) ? 8 : FRAG_UNIT_RAW;
  localparam int UNIT_W        = $clog2(FRAG_UNIT + 1);

  // Base-sum steps: word added in each cycle of the BASE phase.
  localparam logic [2:0] STEP_ID        = 3'd1;
  localparam logic [2:0] STEP_TTL_PROTO = 3'd2;
  localparam logic [2:0] STEP_SRC_HI    = 3'd3;
  localparam logic [2:0] STEP_SRC_LO    = 3'd4;
  localparam logic [2:0] STEP_DST_HI    = 3'd5;
  localparam logic [2:0] STEP_DST_LO    = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BASE  = 7'b0000010,
    ST_TOT   = 7'b0000100,
    ST_FF    = 7'b0001000,
    ST_FOLD1 = 7'b0010000,
    ST_FOLD2 = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  // control state
  state_t                state_r, state_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [FRAG_CNT_W-1:0] frag_cnt_r, frag_cnt_nxt;
  logic [15:0]           id_cnt_r, id_cnt_nxt;
  logic [31:0]           src_addr_r, src_addr_nxt;
  logic [7:0]            ttl_r, ttl_nxt;

  // datapath state
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ACC_W-1:0]      base_r, base_nxt;
  logic [15:0]           rem_r, rem_nxt;
  logic [15:0]           start_r, start_nxt;
  logic [15:0]           id_r, id_nxt;
  logic [31:0]           dest_r, dest_nxt;
  logic [7:0]            proto_r, proto_nxt;

  // shared adder and per-fragment values
  logic [ACC_W-1:0]      add_a_w, add_b_w, sum_w;
  logic [15:0]           base_word_w;
  logic [UNIT_W-1:0]     flen_w;
  logic [15:0]           total_w;
  logic                  mf_w;
  logic                  last_w;
  logic [15:0]           flags_frag_w;

  logic                  in_acc_w, out_acc_w, cfg_acc_w;

  assign in_acc_w  = in_valid && !in_stall;
  assign out_acc_w = out_valid && !out_stall;
  assign cfg_acc_w = cfg_valid && cfg_ready;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign cfg_ready = 1'b1;

  // Fragment length: full unit while more than a unit remains, else the rest.
  // More bytes follow exactly when the remainder exceeds one unit.
  assign mf_w         = (rem_r > 16'(FRAG_UNIT));
  assign flen_w       = mf_w ? UNIT_W'(FRAG_UNIT) : rem_r[UNIT_W-1:0];
  assign total_w      = 16'(HDR_BYTES) + 16'(flen_w);
  assign last_w       = !mf_w || (frag_cnt_r == FRAG_CNT_W'(MAX_RESULTS - 1));
  assign flags_frag_w = {2'b00, mf_w, start_r[15:3]};

  // Fixed header word added in each BASE step.
  always_comb begin
    case (step_r)
      STEP_ID:        base_word_w = id_r;
      STEP_TTL_PROTO: base_word_w = {ttl_r, proto_r};
      STEP_SRC_HI:    base_word_w = src_addr_r[31:16];
      STEP_SRC_LO:    base_word_w = src_addr_r[15:0];
      STEP_DST_HI:    base_word_w = dest_r[31:16];
      STEP_DST_LO:    base_word_w = dest_r[15:0];
      default:        base_word_w = '0;
    endcase
  end

  // Operand select for the one shared adder.
  always_comb begin
    case (state_r)
      ST_BASE: begin
        add_a_w = acc_r;
        add_b_w = ACC_W'(base_word_w);
      end
      ST_TOT: begin
        add_a_w = base_r;
        add_b_w = ACC_W'(total_w);
      end
      ST_FF: begin
        add_a_w = acc_r;
        add_b_w = ACC_W'(flags_frag_w);
      end
      ST_FOLD1, ST_FOLD2: begin
        // end-around carry: low 16 bits plus the carries above them
        add_a_w = ACC_W'(acc_r[15:0]);
        add_b_w = ACC_W'(acc_r[ACC_W-1:16]);
      end
      default: begin
        add_a_w = '0;
        add_b_w = '0;
      end
    endcase
  end

  assign sum_w = add_a_w + add_b_w;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    frag_cnt_nxt = frag_cnt_r;
    id_cnt_nxt   = id_cnt_r;
    src_addr_nxt = src_addr_r;
    ttl_nxt      = ttl_r;
    acc_nxt      = acc_r;
    base_nxt     = base_r;
    rem_nxt      = rem_r;
    start_nxt    = start_r;
    id_nxt       = id_r;
    dest_nxt     = dest_r;
    proto_nxt    = proto_r;

    if (cfg_acc_w) begin
      case (cfg_index)
        CFG_SOURCE_ADDRESS: src_addr_nxt = cfg_data;
        CFG_TIME_TO_LIVE:   ttl_nxt      = cfg_data[7:0];
        default:            ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc_w) begin
          // latch the request and take the next packet id
          rem_nxt      = in_word.payload_length;
          dest_nxt     = in_word.dest_address;
          proto_nxt    = in_word.proto_number;
          id_nxt       = id_cnt_r;
          id_cnt_nxt   = id_cnt_r + 16'd1;
          start_nxt    = '0;
          frag_cnt_nxt = '0;
          acc_nxt      = ACC_W'(VER_IHL_TOS);
          step_nxt     = STEP_ID;
          state_nxt    = ST_BASE;
        end
      end
      ST_BASE: begin
        acc_nxt  = sum_w;
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_DST_LO) begin
          base_nxt  = sum_w;
          state_nxt = ST_TOT;
        end
      end
      ST_TOT: begin
        acc_nxt   = sum_w;
        state_nxt = ST_FF;
      end
      ST_FF: begin
        acc_nxt   = sum_w;
        state_nxt = ST_FOLD1;
      end
      ST_FOLD1: begin
        acc_nxt   = sum_w;
        state_nxt = ST_FOLD2;
      end
      ST_FOLD2: begin
        acc_nxt   = sum_w;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the word until taken, then advance or finish
        if (out_acc_w) begin
          if (last_w) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt      = rem_r - 16'(flen_w);
            start_nxt    = start_r + 16'(flen_w);
            frag_cnt_nxt = frag_cnt_r + FRAG_CNT_W'(1);
            state_nxt    = ST_TOT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      frag_cnt_r <= '0;
      id_cnt_r   <= '0;
      src_addr_r <= '0;
      ttl_r      <= TTL_RESET;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      frag_cnt_r <= frag_cnt_nxt;
      id_cnt_r   <= id_cnt_nxt;
      src_addr_r <= src_addr_nxt;
      ttl_r      <= ttl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    rem_r   <= rem_nxt;
    start_r <= start_nxt;
    id_r    <= id_nxt;
    dest_r  <= dest_nxt;
    proto_r <= proto_nxt;
  end

  // Result word; after the second fold the sum fits 16 bits.
  assign out_word.payload_start           = start_r;
  assign out_word.fragment_payload_length = 11'(flen_w);
  assign out_word.total_length            = total_w[10:0];
  assign out_word.packet_id               = id_r;
  assign out_word.offset_units            = start_r[15:3];
  assign out_word.more_fragments          = mf_w;
  assign out_word.header_checksum         = ~acc_r[15:0];
  assign out_word.last_fragment           = last_w;

endmodule

/* hdl/ipv4_fragment_header_generator_checker.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator port checker
// Watches the top-level ports for consistency of the fragment words.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_defines.svh"

module ipv4_fragment_header_generator_checker import ifhg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic [10:0] total_want_w;
  logic [12:0] offs_want_w;
  logic        mid_frag_w;
  logic        out_hold_w;

  assign total_want_w = out_word.fragment_payload_length + 11'd20;
  assign offs_want_w  = out_word.payload_start[15:3];
  assign mid_frag_w   = out_valid && !out_word.last_fragment;
  assign out_hold_w   = out_valid && out_stall;

  // total length is header plus fragment payload
  `IFHG_ASSERT_NOW(a_total_len, out_valid, out_word.total_length == total_want_w, "bad total")

  // offset field tracks the byte start
  `IFHG_ASSERT_NOW(a_offset, out_valid, out_word.offset_units == offs_want_w, "bad offset")

  // a fragment that is not last always has a follower
  `IFHG_ASSERT_NOW(a_more_frag, mid_frag_w, out_word.more_fragments, "missing more_fragments")

  // a stalled fragment word holds
  `IFHG_ASSERT_NEXT(a_out_hold, out_hold_w, out_valid && $stable(out_word), "stalled word changed")

  // no new request is taken while fragments are going out
  `IFHG_ASSERT_NOW(a_busy, out_valid, in_stall, "input open while emitting")

endmodule

bind ipv4_fragment_header_generator ipv4_fragment_header_generator_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* dv/tb_ipv4_fragment_header_generator.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Drives send requests and register writes into the generator, predicts every
// fragment header word from its own model of the fragmentation and checksum
// rules, and checks each fragment word the block emits against the oldest
// prediction. Directed edge cases first, then random traffic under several
// sender and receiver pacing profiles with different register settings.
// ----------------------------------------------------------------------------
module tb_ipv4_fragment_header_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import ifhg_pkg::*;

  localparam int MTU_BYTES = 1500;
  // Payload bytes per full fragment: MTU minus header, down to a multiple of 8.
  localparam int FRAG_RAW  = (MTU_BYTES - HDR_BYTES) / 8 * 8;
  localparam int FRAG_UNIT = (FRAG_RAW < 8) ? 8 : FRAG_RAW;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 4000;
  // Mismatch lines printed before the report goes quiet (counting continues).
  localparam int REPORT_LINES = 40;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_ADDRESS;
  logic [31:0]          cfg_data  = '0;

  // Shadow of the block's state: registers and the packet id counter.
  logic [31:0] own_address;
  logic [7:0]  hop_limit;
  logic [15:0] next_packet_id;

  // Fragment words predicted but not yet seen on the output.
  out_word_t   frag_expect_q[$];

  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  // Pacing: percent of cycles the sender idles and the receiver stalls.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  ipv4_fragment_header_generator #(
    .MTU_BYTES (MTU_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Internet checksum over the ten header words, checksum word taken as zero.
  function automatic logic [15:0] ip_header_checksum(logic [15:0] total_len,
                                                     logic [15:0] id,
                                                     logic [15:0] flags_offset,
                                                     logic [7:0]  proto,
                                                     logic [31:0] dest);
    logic [31:0] acc;
    acc = 32'(VER_IHL_TOS) + 32'(total_len) + 32'(id) + 32'(flags_offset)
        + 32'({hop_limit, proto})
        + 32'(own_address[31:16]) + 32'(own_address[15:0])
        + 32'(dest[31:16]) + 32'(dest[15:0]);
    // Fold carries back in until the sum fits 16 bits.
    while (acc > 32'h0000_FFFF)
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    return ~acc[15:0];
  endfunction

  // Queue every fragment word one request produces, then advance the id.
  task automatic predict_fragments(input in_word_t req);
    int unsigned len;
    int unsigned count;
    int unsigned start;
    int unsigned flen;
    int unsigned k;
    logic        mf;
    logic [12:0] offs;
    out_word_t   frag;
    len   = req.payload_length;
    count = (len == 0) ? 1 : (len + FRAG_UNIT - 1) / FRAG_UNIT;
    // Small MTUs can ask for more fragments than the block emits: truncate.
    if (count > MAX_RESULTS)
      count = MAX_RESULTS;
    for (k = 0; k < count; k++) begin
      start = k * FRAG_UNIT;
      flen  = (len - start > FRAG_UNIT) ? FRAG_UNIT : len - start;
      mf    = (start + flen < len);
      offs  = 13'(start >> 3);
      frag.payload_start           = 16'(start);
      frag.fragment_payload_length = 11'(flen);
      frag.total_length            = 11'(HDR_BYTES + flen);
      frag.packet_id               = next_packet_id;
      frag.offset_units            = offs;
      frag.more_fragments          = mf;
      frag.header_checksum         = ip_header_checksum(16'(HDR_BYTES + flen),
                                                        next_packet_id,
                                                        {2'b00, mf, offs},
                                                        req.proto_number,
                                                        req.dest_address);
      frag.last_fragment           = (k + 1 == count);
      frag_expect_q.push_back(frag);
    end
    next_packet_id = next_packet_id + 16'd1;
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LINES)
      $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_fragment(input out_word_t got, input out_word_t exp);
    string tag;
    tag = $sformatf("id %0d start %0d:", exp.packet_id, exp.payload_start);
    if (got.payload_start !== exp.payload_start)
      report_mismatch($sformatf("%s payload_start %0d, want %0d", tag,
                                got.payload_start, exp.payload_start));
    if (got.fragment_payload_length !== exp.fragment_payload_length)
      report_mismatch($sformatf("%s fragment_payload_length %0d, want %0d", tag,
                                got.fragment_payload_length,
                                exp.fragment_payload_length));
    if (got.total_length !== exp.total_length)
      report_mismatch($sformatf("%s total_length %0d, want %0d", tag,
                                got.total_length, exp.total_length));
    if (got.packet_id !== exp.packet_id)
      report_mismatch($sformatf("%s packet_id %0d, want %0d", tag,
                                got.packet_id, exp.packet_id));
    if (got.offset_units !== exp.offset_units)
      report_mismatch($sformatf("%s offset_units %0d, want %0d", tag,
                                got.offset_units, exp.offset_units));
    if (got.more_fragments !== exp.more_fragments)
      report_mismatch($sformatf("%s more_fragments %b, want %b", tag,
                                got.more_fragments, exp.more_fragments));
    if (got.header_checksum !== exp.header_checksum)
      report_mismatch($sformatf("%s header_checksum %h, want %h", tag,
                                got.header_checksum, exp.header_checksum));
    if (got.last_fragment !== exp.last_fragment)
      report_mismatch($sformatf("%s last_fragment %b, want %b", tag,
                                got.last_fragment, exp.last_fragment));
  endtask

  // Take every accepted fragment word and match it with the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (frag_expect_q.size() == 0) begin
        report_mismatch($sformatf("fragment word with nothing pending, id %0d start %0d",
                                  out_word.packet_id, out_word.payload_start));
      end else begin
        exp = frag_expect_q.pop_front();
        compare_fragment(out_word, exp);
      end
    end
  end

  // Receiver pacing: stall at random, at the rate the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one request, idling first at the phase's rate; predict on acceptance.
  // Valid stays high after acceptance so back-to-back words need no drop.
  task automatic send_request(input logic [15:0] len, input logic [31:0] dest,
                              input logic [7:0] proto);
    in_word_t req;
    req.payload_length = len;
    req.dest_address   = dest;
    req.proto_number   = proto;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= req;
    do
      @(posedge clk);
    while (in_stall);
    predict_fragments(req);
  endtask

  // Drop valid and hold until every predicted fragment word has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (frag_expect_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do
      @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_SOURCE_ADDRESS: own_address = data;
      CFG_TIME_TO_LIVE:   hop_limit   = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Length mix: mostly one to a few fragments, some right at fragment
  // boundaries, a few tiny ones and a few anywhere up to the field's top.
  function automatic logic [15:0] pick_payload_length();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(99);
    if (sel < 40)
      return 16'($urandom_range(FRAG_UNIT, 0));
    if (sel < 70)
      return 16'($urandom_range(4 * FRAG_UNIT, FRAG_UNIT + 1));
    if (sel < 85) begin
      k = $urandom_range(6, 1);
      return 16'(k * FRAG_UNIT + $urandom_range(2, 0) - 1);
    end
    if (sel < 92)
      return 16'($urandom_range(8, 0));
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  function automatic logic [31:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5)
      return 32'h0000_0000;
    if (sel < 10)
      return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_proto();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5)
      return 8'h00;
    if (sel < 10)
      return 8'hFF;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < items; n++)
      send_request(pick_payload_length(), pick_address(), pick_proto());
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at their reset values: source 0, TTL 64, id from 0.
  task automatic test_reset_defaults();
    send_request(16'd0, 32'hC0A8_0001, 8'd17);
    send_request(16'd1, 32'h0A00_0001, 8'd6);
    send_request(16'(FRAG_UNIT + 1), 32'h7F00_0001, 8'd1);
    wait_drain();
  endtask

  // Lengths around fragment boundaries and at the top of the field, including
  // values past the nominal maximum, with extreme addresses and protocols.
  task automatic test_length_edges();
    send_request(16'd7, 32'h0000_0000, 8'h00);
    send_request(16'd8, 32'hFFFF_FFFF, 8'hFF);
    send_request(16'(FRAG_UNIT - 1), 32'h1234_5678, 8'd17);
    send_request(16'(FRAG_UNIT), 32'hFFFF_FFFF, 8'h00);
    send_request(16'(2 * FRAG_UNIT), 32'h0000_0000, 8'hFF);
    send_request(16'(2 * FRAG_UNIT + 1), 32'hA5A5_5A5A, 8'd6);
    send_request(16'd65515, 32'hFFFF_FFFF, 8'hFF);
    send_request(16'd65516, 32'h8000_0001, 8'd41);
    send_request(16'hFFFF, 32'h0000_0000, 8'h00);
    send_request(16'h8000, 32'h5555_AAAA, 8'h80);
    wait_drain();
  endtask

  // Extreme register values, and writes to unused indexes that must be ignored.
  task automatic test_register_extremes();
    write_register(CFG_SOURCE_ADDRESS, 32'hFFFF_FFFF);
    write_register(CFG_TIME_TO_LIVE, 32'h0000_00FF);
    send_request(16'd0, 32'hFFFF_FFFF, 8'hFF);
    send_request(16'(FRAG_UNIT + 8), 32'h0000_0000, 8'h00);
    wait_drain();
    write_register(CFG_SOURCE_ADDRESS, 32'h0000_0000);
    write_register(CFG_TIME_TO_LIVE, 32'hFFFF_FF00);
    send_request(16'd100, 32'hFFFF_FFFF, 8'hFF);
    wait_drain();
    write_register(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_register(CFG_SPARE_B, $urandom());
    send_request(16'd1, 32'hC0A8_0102, 8'd17);
    send_request(16'(3 * FRAG_UNIT - 1), 32'h0A0B_0C0D, 8'd6);
    wait_drain();
  endtask

  task automatic test_random_no_idle();
    write_register(CFG_SOURCE_ADDRESS, $urandom());
    write_register(CFG_TIME_TO_LIVE, $urandom());
    run_random_phase(0, 0, 88);
  endtask

  task automatic test_random_sender_gaps();
    write_register(CFG_SOURCE_ADDRESS, 32'hFFFF_FFFF);
    write_register(CFG_TIME_TO_LIVE, 32'h0000_00FF);
    run_random_phase(62, 0, 88);
  endtask

  task automatic test_random_receiver_stalls();
    write_register(CFG_SOURCE_ADDRESS, 32'h0000_0000);
    write_register(CFG_TIME_TO_LIVE, 32'h0000_0000);
    run_random_phase(0, 62, 88);
  endtask

  task automatic test_random_both_idle();
    write_register(CFG_SPARE_A, $urandom());
    write_register(CFG_SOURCE_ADDRESS, $urandom());
    write_register(CFG_TIME_TO_LIVE, $urandom());
    write_register(CFG_SPARE_B, $urandom());
    run_random_phase(15, 15, 88);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    own_address    = 32'h0000_0000;
    hop_limit      = TTL_RESET;
    next_packet_id = 16'd0;
    // Hold reset, then release it once for the whole run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_length_edges();
    test_register_extremes();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    // Let any stray word surface before the verdict.
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && frag_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
